### hdl/lavb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_pkg
// Shared types and constants for the camera basis pipeline.
// ----------------------------------------------------------------------------
package lavb_pkg;

    localparam int IW        = 32;              // input field width
    localparam int QVW       = 32;              // Q2.30 result width
    localparam int VW        = 64;              // width of a vector fed to a normaliser
    localparam int MW        = VW - 1;          // magnitude width
    localparam int NW        = 30;              // block-scaled magnitude width
    localparam int SW        = 2 * NW + 2;      // sum of three squares
    localparam int LW        = NW + 1;          // root width
    localparam int NUMW      = NW + LW - 1;     // divider numerator width
    localparam int NS_BITS   = 6;               // leading-zero shift steps
    localparam int NS_SPLIT  = 3;               // steps done in the second shift stage

    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = 16;
    localparam int SQ_ITER   = SQ_PER * SQ_STAGES;
    localparam int SQ_RADW   = 2 * SQ_ITER;
    localparam int SQ_RW     = SQ_ITER + 2;

    localparam int DV_PER    = 2;
    localparam int DV_STAGES = 16;
    localparam int DV_ITER   = DV_PER * DV_STAGES;

    localparam int UNIT_LAT  = 6 + SQ_STAGES + DV_STAGES;
    localparam int CR_LAT    = 2;
    localparam int DL_DEPTH  = CR_LAT + UNIT_LAT;
    localparam int LATENCY   = 2 + 3 * UNIT_LAT + 2 * CR_LAT;

    typedef logic [2:0][QVW-1:0] t_qvec;
    typedef logic [2:0][VW-1:0]  t_wvec;

    typedef struct packed {
        logic signed [IW-1:0] eye_x;
        logic signed [IW-1:0] eye_y;
        logic signed [IW-1:0] eye_z;
        logic signed [IW-1:0] target_x;
        logic signed [IW-1:0] target_y;
        logic signed [IW-1:0] target_z;
        logic signed [IW-1:0] hint_x;
        logic signed [IW-1:0] hint_y;
        logic signed [IW-1:0] hint_z;
    } t_item;

    typedef struct packed {
        logic signed [QVW-1:0] right_x;
        logic signed [QVW-1:0] right_y;
        logic signed [QVW-1:0] right_z;
        logic signed [QVW-1:0] upward_x;
        logic signed [QVW-1:0] upward_y;
        logic signed [QVW-1:0] upward_z;
        logic signed [QVW-1:0] back_x;
        logic signed [QVW-1:0] back_y;
        logic signed [QVW-1:0] back_z;
        logic                  degenerate;
    } t_result;

endpackage

### hdl/lavb_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_sqrt
// Pipelined integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module lavb_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [lavb_pkg::SW-1:0] i_rad,
    output logic                   o_valid,
    output logic [lavb_pkg::LW-1:0] o_root
);
    import lavb_pkg::*;

    typedef struct packed {
        logic [SQ_RW-1:0]   rem;
        logic [SQ_ITER-1:0] root;
        logic [SQ_RADW-1:0] rad;
    } t_sq;

    t_sq                  r_st [SQ_STAGES];
    t_sq                  n_st [SQ_STAGES];
    logic [SQ_STAGES-1:0] r_vld;

    function automatic t_sq sq_step(input t_sq a);
        t_sq              b;
        logic [SQ_RW+1:0] trial;
        logic [SQ_RW+1:0] tst;
        b = a;
        for (int j = 0; j < SQ_PER; j++) begin
            trial = {b.rem, b.rad[SQ_RADW-1 -: 2]};
            tst   = (SQ_RW+2)'({b.root, 2'b01});
            if (trial >= tst) begin
                b.rem  = SQ_RW'(trial - tst);
                b.root = {b.root[SQ_ITER-2:0], 1'b1};
            end else begin
                b.rem  = SQ_RW'(trial);
                b.root = {b.root[SQ_ITER-2:0], 1'b0};
            end
            b.rad = b.rad << 2;
        end
        return b;
    endfunction

    always_comb begin
        t_sq init;
        init.rem  = '0;
        init.root = '0;
        init.rad  = SQ_RADW'(i_rad);
        n_st[0]   = sq_step(init);
        for (int s = 1; s < SQ_STAGES; s++) begin
            n_st[s] = sq_step(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            r_st[s] <= n_st[s];
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_st[SQ_STAGES-1].root[LW-1:0];

endmodule

### hdl/lavb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_div
// Pipelined restoring divider, three numerators over one shared divisor.
// ----------------------------------------------------------------------------
module lavb_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [2:0][lavb_pkg::NUMW-1:0]   i_num,
    input  logic [lavb_pkg::LW-1:0]          i_den,
    output logic                             o_valid,
    output logic [2:0][lavb_pkg::LW-1:0]     o_quo
);
    import lavb_pkg::*;

    typedef struct packed {
        logic [2:0][LW-1:0]      rem;
        logic [2:0][DV_ITER-1:0] low;
        logic [2:0][DV_ITER-1:0] quo;
        logic [LW-1:0]           den;
    } t_dv;

    t_dv                  r_st [DV_STAGES];
    t_dv                  n_st [DV_STAGES];
    logic [DV_STAGES-1:0] r_vld;

    function automatic t_dv dv_step(input t_dv a);
        t_dv         b;
        logic [LW:0] rt;
        b = a;
        for (int j = 0; j < DV_PER; j++) begin
            for (int i = 0; i < 3; i++) begin
                rt       = {b.rem[i], b.low[i][DV_ITER-1]};
                b.low[i] = b.low[i] << 1;
                if (rt >= {1'b0, b.den}) begin
                    b.rem[i] = LW'(rt - {1'b0, b.den});
                    b.quo[i] = {b.quo[i][DV_ITER-2:0], 1'b1};
                end else begin
                    b.rem[i] = LW'(rt);
                    b.quo[i] = {b.quo[i][DV_ITER-2:0], 1'b0};
                end
            end
        end
        return b;
    endfunction

    always_comb begin
        t_dv init;
        for (int i = 0; i < 3; i++) begin
            init.rem[i] = LW'(i_num[i] >> DV_ITER);
            init.low[i] = i_num[i][DV_ITER-1:0];
            init.quo[i] = '0;
        end
        init.den = i_den;
        n_st[0]  = dv_step(init);
        for (int s = 1; s < DV_STAGES; s++) begin
            n_st[s] = dv_step(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DV_STAGES; s++) begin
            r_st[s] <= n_st[s];
        end
    end

    assign o_valid = r_vld[DV_STAGES-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_quo[i] = r_st[DV_STAGES-1].quo[i][LW-1:0];
        end
    end

endmodule

### hdl/lavb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_unit
// Normaliser: block scaling, sum of squares, root and per-component divide.
// ----------------------------------------------------------------------------
module lavb_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lavb_pkg::t_wvec i_vec,
    output logic            o_valid,
    output lavb_pkg::t_qvec o_vec,
    output logic            o_zero
);
    import lavb_pkg::*;

    typedef logic [2:0][MW-1:0] t_mag;
    typedef logic [2:0][NW-1:0] t_nrm;
    typedef struct packed {
        t_nrm       n;
        logic [2:0] sgn;
        logic       zero;
    } t_uside;
    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } t_sflag;

    logic [4:0]           r_vld;
    t_mag                 r1_m, r2_m, n2_m;
    logic [MW-1:0]        r2_orw, n2_orw;
    logic                 n2_zero;
    t_nrm                 r3_n, n3_n, r4_n, r5_n;
    logic [2:0]           r1_sgn, r2_sgn, r3_sgn, r4_sgn, r5_sgn;
    logic                 r2_zero, r3_zero, r4_zero, r5_zero;
    logic [2:0][2*NW-1:0] r4_sq;
    logic [SW-1:0]        r5_s;
    t_uside               r_sd [SQ_STAGES];
    t_sflag               r_dd [DV_STAGES];
    logic                 w_sq_vld, w_dv_vld;
    logic [LW-1:0]        w_root;
    logic [2:0][NUMW-1:0] w_num;
    logic [2:0][LW-1:0]   w_quo;
    t_qvec                r_out;
    logic                 r_zero, r_ovld;

    // leading-zero shift, upper half of the steps; OR word tracks the max
    always_comb begin
        n2_m    = r1_m;
        n2_orw  = r1_m[0] | r1_m[1] | r1_m[2];
        n2_zero = (n2_orw == '0);
        for (int k = NS_BITS - 1; k >= NS_SPLIT; k--) begin
            if ((n2_orw >> (MW - (1 << k))) == '0) begin
                n2_orw = n2_orw << (1 << k);
                for (int i = 0; i < 3; i++) begin
                    n2_m[i] = n2_m[i] << (1 << k);
                end
            end
        end
    end

    // lower steps; top NW bits put the largest magnitude in [2^29, 2^30)
    always_comb begin
        t_mag          m;
        logic [MW-1:0] orw;
        m   = r2_m;
        orw = r2_orw;
        for (int k = NS_SPLIT - 1; k >= 0; k--) begin
            if ((orw >> (MW - (1 << k))) == '0) begin
                orw = orw << (1 << k);
                for (int i = 0; i < 3; i++) begin
                    m[i] = m[i] << (1 << k);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            n3_n[i] = m[i][MW-1 -: NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[3:0], i_valid};
            r_ovld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_m[i]   <= i_vec[i][VW-1] ? MW'(~i_vec[i] + 1'b1) : MW'(i_vec[i]);
            r1_sgn[i] <= i_vec[i][VW-1];
            r4_sq[i]  <= r3_n[i] * r3_n[i];
        end
        r2_m    <= n2_m;
        r2_orw  <= n2_orw;
        r2_zero <= n2_zero;
        r2_sgn  <= r1_sgn;
        r3_n    <= n3_n;
        r3_sgn  <= r2_sgn;
        r3_zero <= r2_zero;
        r4_n    <= r3_n;
        r4_sgn  <= r3_sgn;
        r4_zero <= r3_zero;
        r5_s    <= SW'(r4_sq[0]) + SW'(r4_sq[1]) + SW'(r4_sq[2]);
        r5_n    <= r4_n;
        r5_sgn  <= r4_sgn;
        r5_zero <= r4_zero;
        r_sd[0] <= '{n: r5_n, sgn: r5_sgn, zero: r5_zero};
        for (int s = 1; s < SQ_STAGES; s++) begin
            r_sd[s] <= r_sd[s-1];
        end
        r_dd[0] <= '{sgn: r_sd[SQ_STAGES-1].sgn, zero: r_sd[SQ_STAGES-1].zero};
        for (int s = 1; s < DV_STAGES; s++) begin
            r_dd[s] <= r_dd[s-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_out[i] <= r_dd[DV_STAGES-1].sgn[i] ? (~{1'b0, w_quo[i]} + 1'b1)
                                                 : {1'b0, w_quo[i]};
        end
        r_zero <= r_dd[DV_STAGES-1].zero;
    end

    lavb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[4]),
        .i_rad   (r5_s),
        .o_valid (w_sq_vld),
        .o_root  (w_root)
    );

    // m * 2^30 + floor(L/2): L/2 stays below 2^30, so it just fills the low bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {r_sd[SQ_STAGES-1].n[i], w_root[LW-1:1]};
        end
    end

    lavb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_vld),
        .i_num   (w_num),
        .i_den   (w_root),
        .o_valid (w_dv_vld),
        .o_quo   (w_quo)
    );

    assign o_valid = r_ovld;
    assign o_vec   = r_out;
    assign o_zero  = r_zero;

endmodule

### hdl/lavb_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_cross
// Exact cross product of two Q2.30 vectors, products then differences.
// ----------------------------------------------------------------------------
module lavb_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lavb_pkg::t_qvec i_a,
    input  lavb_pkg::t_qvec i_b,
    output logic            o_valid,
    output lavb_pkg::t_wvec o_vec
);
    import lavb_pkg::*;

    logic signed [VW-1:0] r_p [6];
    t_wvec                r_c;
    logic [1:0]           r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
        r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
        r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
        r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
        r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
        r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
        r_c[0] <= r_p[0] - r_p[1];
        r_c[1] <= r_p[2] - r_p[3];
        r_c[2] <= r_p[4] - r_p[5];
    end

    assign o_valid = r_vld[1];
    assign o_vec   = r_c;

endmodule

### hdl/look_at_view_basis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_basis
// Camera basis (right, upward, back) in Q2.30 from eye, target and up hint.
// Throughput: one transaction per cycle; busy is never raised.
// Four normalisers of 38 stages each (root and divide pipelines);
// three of them in series set the depth.
// Reset (synchronous, active low) clears only the valid bits.
// ----------------------------------------------------------------------------
module look_at_view_basis (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lavb_pkg::t_item   i_item,
    output logic              o_valid,
    output lavb_pkg::t_result o_result
);
    import lavb_pkg::*;

    typedef struct packed {
        t_qvec back;
        logic  z;
    } t_line1;
    typedef struct packed {
        t_qvec back;
        t_qvec right;
        logic  z;
    } t_line2;

    logic          r_vin;
    t_wvec         r_d, r_h;
    logic          w_a_vld, w_h_vld, w_a_zero, w_b_zero, w_t1_vld, w_r_vld, w_r_zero;
    logic          w_t2_vld, w_u_vld, w_u_zero;
    t_qvec         w_back, w_hn, w_right, w_up;
    t_wvec         w_t1, w_t2;
    t_line1        r_l1 [DL_DEPTH];
    t_line2        r_l2 [DL_DEPTH];
    t_result       r_res;
    logic          r_ovld;
    logic [IW:0]   w_diff [3];
    logic          w_deg;

    assign busy = 1'b0;

    always_comb begin
        w_diff[0] = {i_item.eye_x[IW-1], i_item.eye_x}
                  - {i_item.target_x[IW-1], i_item.target_x};
        w_diff[1] = {i_item.eye_y[IW-1], i_item.eye_y}
                  - {i_item.target_y[IW-1], i_item.target_y};
        w_diff[2] = {i_item.eye_z[IW-1], i_item.eye_z}
                  - {i_item.target_z[IW-1], i_item.target_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vin  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_vin  <= start && !busy;
            r_ovld <= w_u_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i] <= {{(VW-IW-1){w_diff[i][IW]}}, w_diff[i]};
        end
        r_h[0] <= {{(VW-IW){i_item.hint_x[IW-1]}}, i_item.hint_x};
        r_h[1] <= {{(VW-IW){i_item.hint_y[IW-1]}}, i_item.hint_y};
        r_h[2] <= {{(VW-IW){i_item.hint_z[IW-1]}}, i_item.hint_z};
    end

    lavb_unit u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_vin), .i_vec (r_d),
        .o_valid (w_a_vld), .o_vec (w_back), .o_zero (w_a_zero)
    );

    lavb_unit u_hint (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_vin), .i_vec (r_h),
        .o_valid (w_h_vld), .o_vec (w_hn), .o_zero (w_b_zero)
    );

    lavb_cross u_cross_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_a_vld && w_h_vld),
        .i_a (w_hn), .i_b (w_back), .o_valid (w_t1_vld), .o_vec (w_t1)
    );

    lavb_unit u_right (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_t1_vld), .i_vec (w_t1),
        .o_valid (w_r_vld), .o_vec (w_right), .o_zero (w_r_zero)
    );

    lavb_cross u_cross_u (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_r_vld),
        .i_a (r_l1[DL_DEPTH-1].back), .i_b (w_right),
        .o_valid (w_t2_vld), .o_vec (w_t2)
    );

    lavb_unit u_upward (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_t2_vld), .i_vec (w_t2),
        .o_valid (w_u_vld), .o_vec (w_up), .o_zero (w_u_zero)
    );

    // side lines keep back, right and the zero flags level with the later stages
    always_ff @(posedge i_clk) begin
        r_l1[0] <= '{back: w_back, z: w_a_zero | w_b_zero};
        r_l2[0] <= '{back: r_l1[DL_DEPTH-1].back, right: w_right,
                     z: r_l1[DL_DEPTH-1].z | w_r_zero};
        for (int i = 1; i < DL_DEPTH; i++) begin
            r_l1[i] <= r_l1[i-1];
            r_l2[i] <= r_l2[i-1];
        end
    end

    assign w_deg = r_l2[DL_DEPTH-1].z | w_u_zero;

    always_ff @(posedge i_clk) begin
        if (w_deg) begin
            r_res <= '{default: '0, degenerate: 1'b1};
        end else begin
            r_res.right_x    <= r_l2[DL_DEPTH-1].right[0];
            r_res.right_y    <= r_l2[DL_DEPTH-1].right[1];
            r_res.right_z    <= r_l2[DL_DEPTH-1].right[2];
            r_res.upward_x   <= w_up[0];
            r_res.upward_y   <= w_up[1];
            r_res.upward_z   <= w_up[2];
            r_res.back_x     <= r_l2[DL_DEPTH-1].back[0];
            r_res.back_y     <= r_l2[DL_DEPTH-1].back[1];
            r_res.back_z     <= r_l2[DL_DEPTH-1].back[2];
            r_res.degenerate <= 1'b0;
        end
    end

    assign o_valid  = r_ovld;
    assign o_result = r_res;

endmodule
